// ----- hw/rtl/spt_pkg.sv -----
// Shared types, constants and helpers for the sweep peak tracker.
package spt_pkg;

  localparam int FREQ_BITS_DEF   = 30;
  localparam int FILTER_FRAC_DEF = 16;

  localparam int RSSI_W  = 11;
  localparam int RAW_W   = 8;
  localparam int CHAN_W  = 8;
  localparam int COMP_W  = 8;
  localparam int HOLD_W  = 8;
  localparam int GAIN_W  = 16;
  localparam int IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [RSSI_W-1:0] PEAK_FLOOR  = -11'sd254;
  localparam logic signed [RSSI_W-1:0] RSSI_OFFSET = 11'sd140;

  // register reset values
  localparam logic [COMP_W-1:0]        RST_RSSI_COMP = '0;
  localparam logic signed [RSSI_W-1:0] RST_THRESHOLD = -11'sd150;
  localparam logic [HOLD_W-1:0]        RST_HOLD      = 8'd20;
  localparam int                       RST_JUMP      = 500000;
  localparam logic [GAIN_W-1:0]        RST_FAST_GAIN = 16'd58982;
  localparam logic [GAIN_W-1:0]        RST_SLOW_GAIN = 16'd1966;

  // tunable bands, limits included
  localparam logic [31:0] BAND0_LO = 32'd142000000;
  localparam logic [31:0] BAND0_HI = 32'd175000000;
  localparam logic [31:0] BAND1_LO = 32'd284000000;
  localparam logic [31:0] BAND1_HI = 32'd525000000;
  localparam logic [31:0] BAND2_LO = 32'd850000000;
  localparam logic [31:0] BAND2_HI = 32'd1050000000;

  typedef enum logic [IDX_W-1:0] {
    REG_RSSI_COMP = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_HOLD      = 3'd2,
    REG_JUMP      = 3'd3,
    REG_FAST_GAIN = 3'd4,
    REG_SLOW_GAIN = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [COMP_W-1:0]        rssi_comp;
    logic signed [RSSI_W-1:0] threshold;
    logic [HOLD_W-1:0]        hold_reload;
    logic [GAIN_W-1:0]        fast_gain;
    logic [GAIN_W-1:0]        slow_gain;
  } cfg_t;

  function automatic logic in_band(input logic [31:0] f);
    in_band = (f >= BAND0_LO && f <= BAND0_HI) ||
              (f >= BAND1_LO && f <= BAND1_HI) ||
              (f >= BAND2_LO && f <= BAND2_HI);
  endfunction

endpackage

// ----- hw/rtl/sweep_peak_tracker.sv -----
// Top level of the sweep peak tracker: config registers, front end, queue, back end.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in_     | input     | in_valid / in_ready    | frequency_hz, rssi_raw, channel_index,
//          |           |                        | sweep_end
//  out_    | output    | out_valid / out_ready  | report_frequency_hz, report_rssi_half_db,
//          |           |                        | report_channel, signal_present
//  cfg_    | input     | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// Measurements inside a sweep are taken one per cycle while the queue has room; the
// front end only folds them into the running peak. Each sweep end hands a summary to a
// 2-entry queue. The back end retires a hold countdown in idle, sends a seed or clear
// report to done, and runs a filtered report through diff, gain, a digit-serial 16x16
// multiply over NCH 16-bit digits of the Q-format filter word (3 by default), update
// and done. Reset is synchronous; no clearing pass is needed. A stalled output only
// stops the back end; the front keeps taking transactions until the queue fills.
module sweep_peak_tracker #(
  parameter int FREQ_BITS        = spt_pkg::FREQ_BITS_DEF,
  parameter int FILTER_FRAC_BITS = spt_pkg::FILTER_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // measurement channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [FREQ_BITS-1:0]              in_frequency_hz,
  input  logic [spt_pkg::RAW_W-1:0]         in_rssi_raw,
  input  logic [spt_pkg::CHAN_W-1:0]        in_channel_index,
  input  logic                              in_sweep_end,
  // report channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [FREQ_BITS-1:0]              out_report_frequency_hz,
  output logic signed [spt_pkg::RSSI_W-1:0] out_report_rssi_half_db,
  output logic [spt_pkg::CHAN_W-1:0]        out_report_channel,
  output logic                              out_signal_present,
  // configuration
  input  logic                              cfg_we,
  input  logic [spt_pkg::IDX_W-1:0]         cfg_index,
  input  logic [FREQ_BITS-1:0]              cfg_wdata
);
  import spt_pkg::*;

  localparam int SUM_W = RSSI_W + FREQ_BITS + CHAN_W + 1;

  cfg_t                 cfg_r;
  logic [FREQ_BITS-1:0] jump_limit_r;

  logic                 sum_valid;
  logic                 sum_ready;
  logic [SUM_W-1:0]     sum_data;
  logic                 q_valid;
  logic                 q_ready;
  logic [SUM_W-1:0]     q_data;

  // user writes config only while idle, not enforced; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rssi_comp   <= RST_RSSI_COMP;
      cfg_r.threshold   <= RST_THRESHOLD;
      cfg_r.hold_reload <= RST_HOLD;
      cfg_r.fast_gain   <= RST_FAST_GAIN;
      cfg_r.slow_gain   <= RST_SLOW_GAIN;
      jump_limit_r      <= FREQ_BITS'(RST_JUMP);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RSSI_COMP: cfg_r.rssi_comp   <= cfg_wdata[COMP_W-1:0];
        REG_THRESHOLD: cfg_r.threshold   <= $signed(cfg_wdata[RSSI_W-1:0]);
        REG_HOLD:      cfg_r.hold_reload <= cfg_wdata[HOLD_W-1:0];
        REG_JUMP:      jump_limit_r      <= cfg_wdata;
        REG_FAST_GAIN: cfg_r.fast_gain   <= cfg_wdata[GAIN_W-1:0];
        REG_SLOW_GAIN: cfg_r.slow_gain   <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  spt_front #(
    .FREQ_BITS(FREQ_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_frequency_hz  (in_frequency_hz),
    .in_rssi_raw      (in_rssi_raw),
    .in_channel_index (in_channel_index),
    .in_sweep_end     (in_sweep_end),
    .rssi_comp        (cfg_r.rssi_comp),
    .sum_valid        (sum_valid),
    .sum_ready        (sum_ready),
    .sum_data         (sum_data)
  );

  spt_queue #(
    .DATA_W(SUM_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (sum_valid),
    .push_ready (sum_ready),
    .push_data  (sum_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  spt_back #(
    .FREQ_BITS        (FREQ_BITS),
    .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
  ) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg                     (cfg_r),
    .jump_limit              (jump_limit_r),
    .sum_valid               (q_valid),
    .sum_ready               (q_ready),
    .sum_data                (q_data),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_report_frequency_hz (out_report_frequency_hz),
    .out_report_rssi_half_db (out_report_rssi_half_db),
    .out_report_channel      (out_report_channel),
    .out_signal_present      (out_signal_present)
  );

endmodule

// ----- hw/rtl/spt_front.sv -----
// Front end: accepts measurements, tracks the sweep peak, emits one summary per sweep.
module spt_front #(
  parameter int FREQ_BITS = spt_pkg::FREQ_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [FREQ_BITS-1:0]                          in_frequency_hz,
  input  logic [spt_pkg::RAW_W-1:0]                     in_rssi_raw,
  input  logic [spt_pkg::CHAN_W-1:0]                    in_channel_index,
  input  logic                                          in_sweep_end,
  input  logic [spt_pkg::COMP_W-1:0]                    rssi_comp,
  output logic                                          sum_valid,
  input  logic                                          sum_ready,
  output logic [spt_pkg::RSSI_W+FREQ_BITS+spt_pkg::CHAN_W:0] sum_data
);
  import spt_pkg::*;

  typedef struct packed {
    logic                     fresh;
    logic signed [RSSI_W-1:0] rssi;
    logic [FREQ_BITS-1:0]     freq;
    logic [CHAN_W-1:0]        chan;
  } sum_t;

  logic signed [RSSI_W-1:0] peak_rssi_r;
  logic [FREQ_BITS-1:0]     peak_freq_r;
  logic [CHAN_W-1:0]        peak_chan_r;
  logic                     fresh_r;

  logic                     accept;
  logic signed [RSSI_W-1:0] rssi_now;
  logic                     take;
  sum_t                     sum;

  assign in_ready = sum_ready;
  assign accept   = in_valid && in_ready;

  // raw - 2*comp - 140, result always within 11 bits signed
  assign rssi_now = $signed({3'b000, in_rssi_raw}) - $signed({2'b00, rssi_comp, 1'b0})
                    - RSSI_OFFSET;
  assign take = in_band(32'(in_frequency_hz)) && (rssi_now > peak_rssi_r);

  always_comb begin
    sum.fresh = fresh_r || take;
    sum.rssi  = take ? rssi_now : peak_rssi_r;
    sum.freq  = take ? in_frequency_hz : peak_freq_r;
    sum.chan  = take ? in_channel_index : peak_chan_r;
  end

  assign sum_valid = accept && in_sweep_end;
  assign sum_data  = sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_rssi_r <= PEAK_FLOOR;
      fresh_r     <= 1'b0;
    end else if (accept) begin
      if (in_sweep_end) begin
        peak_rssi_r <= PEAK_FLOOR;
        fresh_r     <= 1'b0;
      end else if (take) begin
        peak_rssi_r <= rssi_now;
        peak_freq_r <= in_frequency_hz;
        peak_chan_r <= in_channel_index;
        fresh_r     <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/spt_queue.sv -----
// Small register FIFO between front and back ends.
module spt_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);
  import spt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = cnt_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/spt_back.sv -----
// Back end: per-sweep decision, hold countdown and adaptive frequency filter.
module spt_back #(
  parameter int FREQ_BITS        = spt_pkg::FREQ_BITS_DEF,
  parameter int FILTER_FRAC_BITS = spt_pkg::FILTER_FRAC_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  spt_pkg::cfg_t                                 cfg,
  input  logic [FREQ_BITS-1:0]                          jump_limit,
  input  logic                                          sum_valid,
  output logic                                          sum_ready,
  input  logic [spt_pkg::RSSI_W+FREQ_BITS+spt_pkg::CHAN_W:0] sum_data,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [FREQ_BITS-1:0]                          out_report_frequency_hz,
  output logic signed [spt_pkg::RSSI_W-1:0]             out_report_rssi_half_db,
  output logic [spt_pkg::CHAN_W-1:0]                    out_report_channel,
  output logic                                          out_signal_present
);
  import spt_pkg::*;

  localparam int FW  = FREQ_BITS + FILTER_FRAC_BITS;
  localparam int NCH = (FW + GAIN_W - 1) / GAIN_W;
  localparam int PW  = NCH * GAIN_W;
  localparam int AW  = FW + GAIN_W;
  localparam int CW  = $clog2(NCH + 1);

  typedef struct packed {
    logic                     fresh;
    logic signed [RSSI_W-1:0] rssi;
    logic [FREQ_BITS-1:0]     freq;
    logic [CHAN_W-1:0]        chan;
  } sum_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_GAIN,
    S_MUL,
    S_UPD,
    S_DONE
  } state_t;

  state_t                   state_r;
  logic [FW-1:0]            filter_r;
  logic [HOLD_W-1:0]        hold_r;
  logic [FREQ_BITS-1:0]     last_freq_r;
  logic [CHAN_W-1:0]        last_chan_r;

  logic [FREQ_BITS-1:0]     job_freq_r;
  logic                     up_r;
  logic [FW-1:0]            mag_r;
  logic [GAIN_W-1:0]        gain_r;
  logic [PW-1:0]            sh_r;
  logic [2*GAIN_W-1:0]      prod_r;
  logic [AW-1:0]            acc_r;
  logic [CW-1:0]            cnt_r;

  logic [FREQ_BITS-1:0]     res_freq_r;
  logic signed [RSSI_W-1:0] res_rssi_r;
  logic [CHAN_W-1:0]        res_chan_r;
  logic                     res_present_r;

  logic                     out_valid_r;
  logic [FREQ_BITS-1:0]     out_freq_r;
  logic signed [RSSI_W-1:0] out_rssi_r;
  logic [CHAN_W-1:0]        out_chan_r;
  logic                     out_present_r;

  sum_t                     job;
  logic [FREQ_BITS-1:0]     sel_freq;
  logic [CHAN_W-1:0]        sel_chan;
  logic                     detect;
  logic [FW-1:0]            n_val;
  logic [FW-1:0]            lim;
  logic                     up;
  logic [2*GAIN_W-1:0]      prod_nxt;
  logic [AW-1:0]            acc_nxt;
  logic [FW-1:0]            step;
  logic [FW-1:0]            filter_upd;

  assign job      = sum_data;
  // no in-band reading this sweep: keep the previous peak frequency/channel
  assign sel_freq = job.fresh ? job.freq : last_freq_r;
  assign sel_chan = job.fresh ? job.chan : last_chan_r;
  assign detect   = $signed(job.rssi) > $signed(cfg.threshold);

  assign n_val    = {job_freq_r, {FILTER_FRAC_BITS{1'b0}}};
  assign lim      = {jump_limit, {FILTER_FRAC_BITS{1'b0}}};
  assign up       = n_val >= filter_r;

  // mag * gain, one 16-bit digit of mag per cycle, MSB digit first
  assign prod_nxt = sh_r[PW-1 -: GAIN_W] * gain_r;
  assign acc_nxt  = (acc_r << GAIN_W) + AW'(prod_r);

  assign step       = acc_r[AW-1:GAIN_W];
  assign filter_upd = up_r ? filter_r + step : filter_r - step;

  assign sum_ready = state_r == S_IDLE;

  assign out_valid               = out_valid_r;
  assign out_report_frequency_hz = out_freq_r;
  assign out_report_rssi_half_db = out_rssi_r;
  assign out_report_channel      = out_chan_r;
  assign out_signal_present      = out_present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      filter_r    <= '0;
      hold_r      <= '0;
      last_freq_r <= '0;
      last_chan_r <= '0;
    end else begin
      // output slot: load a finished report, or free the slot once taken
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (sum_valid) begin
            last_chan_r   <= sel_chan;
            last_freq_r   <= sel_freq;
            job_freq_r    <= sel_freq;
            if (detect) begin
              hold_r        <= cfg.hold_reload;
              res_rssi_r    <= job.rssi;
              res_chan_r    <= sel_chan;
              res_present_r <= 1'b1;
              if (filter_r == '0) begin
                // seed the filter, report the raw peak
                filter_r   <= {sel_freq, {FILTER_FRAC_BITS{1'b0}}};
                res_freq_r <= sel_freq;
                state_r    <= S_DONE;
              end else begin
                state_r <= S_DIFF;
              end
            end else if (hold_r != '0) begin
              hold_r <= hold_r - 1'b1;
            end else begin
              filter_r      <= '0;
              res_freq_r    <= '0;
              res_rssi_r    <= '0;
              res_chan_r    <= '0;
              res_present_r <= 1'b0;
              state_r       <= S_DONE;
            end
          end
        end
        S_DIFF: begin
          up_r    <= up;
          mag_r   <= up ? n_val - filter_r : filter_r - n_val;
          state_r <= S_GAIN;
        end
        S_GAIN: begin
          gain_r  <= (mag_r > lim) ? cfg.fast_gain : cfg.slow_gain;
          sh_r    <= PW'(mag_r);
          acc_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (cnt_r != CW'(NCH)) begin
            prod_r <= prod_nxt;
            sh_r   <= sh_r << GAIN_W;
          end
          if (cnt_r != '0) begin
            acc_r <= acc_nxt;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(NCH)) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          filter_r    <= filter_upd;
          res_freq_r  <= filter_upd[FW-1:FILTER_FRAC_BITS];
          last_freq_r <= filter_upd[FW-1:FILTER_FRAC_BITS];
          state_r     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_freq_r    <= res_freq_r;
            out_rssi_r    <= res_rssi_r;
            out_chan_r    <= res_chan_r;
            out_present_r <= res_present_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/spt_checker.sv -----
// Port-level checks on the sweep peak tracker, bound to the top level.
module spt_checker #(
  parameter int FREQ_BITS = spt_pkg::FREQ_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [FREQ_BITS-1:0]              out_report_frequency_hz,
  input logic signed [spt_pkg::RSSI_W-1:0] out_report_rssi_half_db,
  input logic [spt_pkg::CHAN_W-1:0]        out_report_channel,
  input logic                              out_signal_present
);

  // a held report stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("report dropped while stalled");

  // a held report keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_report_frequency_hz) &&
      $stable(out_report_rssi_half_db) && $stable(out_report_channel) &&
      $stable(out_signal_present))
    else $error("report payload changed while stalled");

  // a cleared report carries all zeros
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_signal_present |-> out_report_frequency_hz == '0 &&
      out_report_rssi_half_db == '0 && out_report_channel == '0)
    else $error("cleared report with nonzero fields");

  // nothing reported straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("report valid after reset");

endmodule

bind sweep_peak_tracker spt_checker #(
  .FREQ_BITS(FREQ_BITS)
) u_spt_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_valid               (out_valid),
  .out_ready               (out_ready),
  .out_report_frequency_hz (out_report_frequency_hz),
  .out_report_rssi_half_db (out_report_rssi_half_db),
  .out_report_channel      (out_report_channel),
  .out_signal_present      (out_signal_present)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for sweep_peak_tracker: directed and random sweeps, scoreboard.
module tb_top;
  import spt_pkg::*;

  localparam int FREQ_W = FREQ_BITS_DEF;
  localparam int FRAC_W = FILTER_FRAC_DEF;

  // index space is 3 bits wide, the top two indexes map to no register
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [RSSI_W-1:0] THR_MIN = -11'sd650;
  localparam logic signed [RSSI_W-1:0] THR_MAX = 11'sd115;
  localparam logic [FREQ_W-1:0]        FREQ_MAX = '1;

  localparam int LONG_HOLD_OFF = 300;    // receiver hold-off, long enough to back up the queue
  localparam int SETTLE_CYCLES = 40;     // two queued summaries to retire, with margin
  localparam int CYCLE_LIMIT   = 250000;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [RAW_W-1:0]  raw;
    logic [CHAN_W-1:0] chan;
    logic              last;
  } meas_t;

  typedef struct packed {
    logic [FREQ_W-1:0]        freq;
    logic signed [RSSI_W-1:0] rssi;
    logic [CHAN_W-1:0]        chan;
    logic                     present;
  } report_t;

  // ---------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [FREQ_W-1:0]        in_frequency_hz = '0;
  logic [RAW_W-1:0]         in_rssi_raw = '0;
  logic [CHAN_W-1:0]        in_channel_index = '0;
  logic                     in_sweep_end = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [FREQ_W-1:0]        out_report_frequency_hz;
  logic signed [RSSI_W-1:0] out_report_rssi_half_db;
  logic [CHAN_W-1:0]        out_report_channel;
  logic                     out_signal_present;
  logic                     cfg_we = 1'b0;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [FREQ_W-1:0]        cfg_wdata = '0;

  sweep_peak_tracker i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_frequency_hz         (in_frequency_hz),
    .in_rssi_raw             (in_rssi_raw),
    .in_channel_index        (in_channel_index),
    .in_sweep_end            (in_sweep_end),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_report_frequency_hz (out_report_frequency_hz),
    .out_report_rssi_half_db (out_report_rssi_half_db),
    .out_report_channel      (out_report_channel),
    .out_signal_present      (out_signal_present),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the register file and of the tracker state
  // ---------------------------------------------------------------------------
  logic [COMP_W-1:0] comp_cfg = RST_RSSI_COMP;
  int                thr_cfg  = int'(RST_THRESHOLD);
  logic [HOLD_W-1:0] hold_cfg = RST_HOLD;
  logic [FREQ_W-1:0] jump_cfg = FREQ_W'(RST_JUMP);
  logic [GAIN_W-1:0] fast_cfg = RST_FAST_GAIN;
  logic [GAIN_W-1:0] slow_cfg = RST_SLOW_GAIN;

  int                peak_q   = int'(PEAK_FLOOR);   // strongest half-dB reading of the open sweep
  logic [FREQ_W-1:0] peak_hz  = '0;
  logic [CHAN_W-1:0] peak_ch  = '0;
  logic [63:0]       smooth_q = '0;           // filter word, Q30.16 hertz
  logic [HOLD_W-1:0] hold_left = '0;

  // testbench bookkeeping
  meas_t       meas_backlog[$];   // measurements waiting for the driver
  report_t     due_reports[$];    // reports the tracker owes, oldest first
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned n_detect = 0;
  int unsigned n_cleared = 0;
  int unsigned n_settings = 0;
  int unsigned stall_asks = 0;    // bumped by the sequencer, consumed by the receiver
  int unsigned cycle_cnt = 0;
  logic        in_acc = 1'b0;     // input transaction completed at the last rising edge

  function automatic bit in_tuned_band(input logic [FREQ_W-1:0] f);
    logic [31:0] w;
    w = 32'(f);
    return (w >= BAND0_LO && w <= BAND0_HI) ||
           (w >= BAND1_LO && w <= BAND1_HI) ||
           (w >= BAND2_LO && w <= BAND2_HI);
  endfunction

  // Folds one measurement into the mirror state; returns 1 when the sweep end owes a report.
  function automatic bit track_measurement(input meas_t m, output report_t r);
    int          rssi;
    logic [63:0] target, lim, mag, step, gain;
    logic [FREQ_W-1:0] rep;
    bit          up;
    bit          owed;
    owed = 1'b0;
    r    = '0;
    if (in_tuned_band(m.freq)) begin
      rssi = int'(m.raw) - 2 * int'(comp_cfg) - int'(RSSI_OFFSET);
      if (rssi > peak_q) begin   // ties keep the earlier reading
        peak_q  = rssi;
        peak_hz = m.freq;
        peak_ch = m.chan;
      end
    end
    if (m.last) begin
      if (peak_q > thr_cfg) begin
        hold_left = hold_cfg;
        if (smooth_q != 0) begin
          target   = 64'(peak_hz) << FRAC_W;
          lim      = 64'(jump_cfg) << FRAC_W;
          up       = target >= smooth_q;
          mag      = up ? target - smooth_q : smooth_q - target;
          gain     = (mag > lim) ? 64'(fast_cfg) : 64'(slow_cfg);
          // Q0.16 gain, step truncated toward zero
          step     = (mag >> 16) * gain + (((mag & 64'hFFFF) * gain) >> 16);
          smooth_q = up ? smooth_q + step : smooth_q - step;
          rep      = FREQ_W'(smooth_q >> FRAC_W);
        end else begin
          // empty filter: seed it, report the raw peak
          smooth_q = 64'(peak_hz) << FRAC_W;
          rep      = peak_hz;
        end
        peak_hz   = rep;
        r.freq    = rep;
        r.rssi    = RSSI_W'(peak_q);
        r.chan    = peak_ch;
        r.present = 1'b1;
        owed      = 1'b1;
      end else if (hold_left > 0) begin
        hold_left = hold_left - 1'b1;   // quiet sweep inside the hold window
      end else begin
        smooth_q = '0;                  // hold expired: clear and report zeros
        owed     = 1'b1;
      end
      peak_q = int'(PEAK_FLOOR);
    end
    return owed;
  endfunction

  task automatic check_report(input report_t got);
    report_t want;
    if (due_reports.size() == 0) begin
      n_errors++;
      $display("%0t ns: unexpected report freq=%0d rssi=%0d chan=%0d present=%0b", $time,
               got.freq, got.rssi, got.chan, got.present);
    end else begin
      want = due_reports.pop_front();
      if (got.freq !== want.freq) begin
        n_errors++;
        $display("%0t ns: report_frequency_hz expected %0d actual %0d", $time,
                 want.freq, got.freq);
      end
      if (got.rssi !== want.rssi) begin
        n_errors++;
        $display("%0t ns: report_rssi_half_db expected %0d actual %0d", $time,
                 want.rssi, got.rssi);
      end
      if (got.chan !== want.chan) begin
        n_errors++;
        $display("%0t ns: report_channel expected %0d actual %0d", $time, want.chan, got.chan);
      end
      if (got.present !== want.present) begin
        n_errors++;
        $display("%0t ns: signal_present expected %0b actual %0b", $time,
                 want.present, got.present);
      end
    end
    if (got.present === 1'b1) n_detect++;
    else n_cleared++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge.
  // The output is checked before the input is predicted: a report can never
  // leave in the same cycle its sweep end enters.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    meas_t   m;
    report_t owed_r;
    if (!rst_n) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= in_valid && in_ready;
      if (out_valid && out_ready)
        check_report('{freq: out_report_frequency_hz, rssi: out_report_rssi_half_db,
                       chan: out_report_channel, present: out_signal_present});
      if (in_valid && in_ready) begin
        n_accepted <= n_accepted + 1;
        m = '{freq: in_frequency_hz, raw: in_rssi_raw, chan: in_channel_index,
              last: in_sweep_end};
        if (track_measurement(m, owed_r)) due_reports.push_back(owed_r);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles, %0d reports still owed", $time,
               cycle_cnt, due_reports.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. Payload and
  // valid only move at the falling edge, and only once the current
  // transaction has gone through.
  // ---------------------------------------------------------------------------
  int    burst_left = 0;
  int    gap_left = 0;

  always @(negedge clk) begin
    meas_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_acc) begin
      // still waiting on in_ready: hold valid and payload
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      in_valid <= 1'b0;
    end else if (meas_backlog.size() > 0) begin
      nxt = meas_backlog.pop_front();
      in_valid         <= 1'b1;
      in_frequency_hz  <= nxt.freq;
      in_rssi_raw      <= nxt.raw;
      in_channel_index <= nxt.chan;
      in_sweep_end     <= nxt.last;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 16);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end else begin
        burst_left = burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: a 16-bit ready pattern, redrawn when its age counter wraps (always ready,
  // random, or sparse). A request from the sequencer starts a long hold-off.
  // ---------------------------------------------------------------------------
  int unsigned stall_seen = 0;
  int          hold_off = 0;
  logic [15:0] ready_pat = '1;
  int          pat_age = 0;

  always @(negedge clk) begin
    if (stall_seen != stall_asks) begin
      stall_seen = stall_asks;
      hold_off   = LONG_HOLD_OFF;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off   = hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(0, 2))
          0:       ready_pat = '1;
          1:       ready_pat = 16'($urandom);
          default: ready_pat = 16'($urandom & $urandom);
        endcase
      end
      out_ready <= ready_pat[4'(pat_age % 16)];
      pat_age    = (pat_age == 47) ? 0 : pat_age + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------------

  // Register write; only called while the tracker is idle, so the mirror
  // can follow at once.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [FREQ_W-1:0] data);
    logic signed [RSSI_W-1:0] t;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    t = data[RSSI_W-1:0];
    case (idx)
      REG_RSSI_COMP: comp_cfg = data[COMP_W-1:0];
      REG_THRESHOLD: thr_cfg  = int'(t);
      REG_HOLD:      hold_cfg = data[HOLD_W-1:0];
      REG_JUMP:      jump_cfg = data;
      REG_FAST_GAIN: fast_cfg = data[GAIN_W-1:0];
      REG_SLOW_GAIN: slow_cfg = data[GAIN_W-1:0];
      default: ;   // unmapped index, write is dropped
    endcase
  endtask

  task automatic queue_meas(input logic [FREQ_W-1:0] f, input logic [RAW_W-1:0] raw,
                            input logic [CHAN_W-1:0] ch, input logic last);
    meas_backlog.push_back('{freq: f, raw: raw, chan: ch, last: last});
    n_queued++;
  endtask

  // Everything sent is through and no report is owed; then give the back
  // end time to retire summaries that produce no report (hold countdown).
  task automatic settle();
    do @(negedge clk); while (n_accepted != n_queued || due_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // In-band frequency most of the time, band limits and the hertz just outside them often.
  function automatic logic [FREQ_W-1:0] pick_band_freq();
    int unsigned lo, hi;
    case ($urandom_range(0, 2))
      0:       begin lo = BAND0_LO; hi = BAND0_HI; end
      1:       begin lo = BAND1_LO; hi = BAND1_HI; end
      default: begin lo = BAND2_LO; hi = BAND2_HI; end
    endcase
    case ($urandom_range(0, 9))
      0:       return FREQ_W'(lo);
      1:       return FREQ_W'(hi);
      2:       return FREQ_W'(lo - 1);
      3:       return FREQ_W'(hi + 1);
      default: return FREQ_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // Well-formed sweeps around a strong emitter that drifts or hops, with
  // out-of-band noise and the odd stray sweep end.
  task automatic queue_sweeps(input int n_items);
    int                left, len, k;
    logic [FREQ_W-1:0] tx, f;
    logic [RAW_W-1:0]  raw;
    left = n_items;
    tx   = pick_band_freq();
    while (left > 0) begin
      len = $urandom_range(1, 8);
      if (len > left) len = left;
      if ($urandom_range(0, 4) == 0) tx = pick_band_freq();
      for (k = 0; k < len; k++) begin
        raw = RAW_W'($urandom);
        case ($urandom_range(0, 9))
          0: f = FREQ_W'($urandom);                                   // full-range noise
          1, 2, 3: begin                                              // the emitter, jittered
            f   = tx + FREQ_W'($urandom_range(0, 2000000)) - FREQ_W'(1000000);
            raw = RAW_W'($urandom_range(150, 255));
          end
          default: f = pick_band_freq();
        endcase
        queue_meas(f, raw, CHAN_W'($urandom),
                   (k == len - 1) || ($urandom_range(0, 15) == 0));
      end
      left = left - len;
    end
  endtask

  task automatic random_config(input bit wild);
    int                       c, tv;
    logic signed [RSSI_W-1:0] t;
    c  = wild ? $urandom_range(0, 255) : $urandom_range(0, 40);
    // threshold drawn from below the emitter's readings up into their span; anywhere when wild
    tv = wild ? int'($urandom_range(0, 765)) - 650
              : -2 * c - 140 + int'($urandom_range(60, 240));
    if (tv > 115) tv = 115;
    if (tv < -650) tv = -650;
    t = RSSI_W'(tv);
    write_reg(REG_RSSI_COMP, FREQ_W'(c));
    write_reg(REG_THRESHOLD, {19'd0, t});
    write_reg(REG_HOLD, FREQ_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 3)));
    write_reg(REG_JUMP, FREQ_W'(wild ? $urandom : $urandom_range(0, 2000000)));
    write_reg(REG_FAST_GAIN, FREQ_W'($urandom_range(0, 65535)));
    write_reg(REG_SLOW_GAIN, FREQ_W'($urandom_range(0, 65535)));
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer. Backlog and stall requests are touched just after a rising
  // edge, the driver and receiver work at the falling edge.
  // ---------------------------------------------------------------------------
  initial begin
    int ph, k;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: band limits, tie on the peak, first report seeds the
    // filter, big jump takes fast gain, out-of-band sweep ends count the hold down.
    n_settings++;
    @(posedge clk);
    queue_meas(142000000, 255, 0, 1'b0);
    queue_meas(141999999, 255, 77, 1'b0);
    queue_meas(175000000, 255, 255, 1'b1);
    queue_meas(175000001, 200, 1, 1'b0);
    queue_meas(283999999, 200, 2, 1'b0);
    queue_meas(284000000, 100, 7, 1'b0);
    queue_meas(525000000, 101, 8, 1'b1);
    queue_meas(525000001, 255, 9, 1'b1);
    queue_meas(849999999, 0, 10, 1'b0);
    queue_meas(850000000, 0, 3, 1'b0);
    queue_meas(1050000000, 9, 255, 1'b1);
    queue_meas(1050000001, 255, 11, 1'b0);
    queue_meas(0, 0, 0, 1'b1);
    queue_meas(FREQ_MAX, 255, 255, 1'b1);
    settle();

    // Hold reload of zero: one quiet sweep clears, next detection seeds again.
    write_reg(REG_HOLD, 0);
    n_settings++;
    @(posedge clk);
    queue_meas(400000000, 200, 1, 1'b1);
    queue_meas(0, 255, 2, 1'b1);
    queue_meas(1000000000, 250, 3, 1'b1);
    settle();

    // Extremes: max compensation, lowest threshold (strictly-above compare),
    // max hold, zero jump limit, full fast gain, zero slow gain.
    write_reg(REG_RSSI_COMP, 255);
    write_reg(REG_THRESHOLD, {19'd0, THR_MIN});
    write_reg(REG_HOLD, 255);
    write_reg(REG_JUMP, 0);
    write_reg(REG_FAST_GAIN, 65535);
    write_reg(REG_SLOW_GAIN, 0);
    n_settings++;
    @(posedge clk);
    queue_meas(300000000, 0, 4, 1'b1);
    queue_meas(300000000, 1, 4, 1'b1);
    queue_meas(900000000, 255, 5, 1'b1);
    queue_meas(900000000, 255, 6, 1'b1);
    queue_meas(0, 0, 9, 1'b1);          // no reading, threshold below floor: reported
    settle();

    // Threshold just below the floor, max jump limit (always slow), full slow
    // gain, max threshold written after this group; unmapped indexes ignored.
    write_reg(REG_RSSI_COMP, 0);
    write_reg(REG_THRESHOLD, {19'd0, -11'sd255});
    write_reg(REG_JUMP, FREQ_MAX);
    write_reg(REG_FAST_GAIN, 0);
    write_reg(REG_SLOW_GAIN, 65535);
    write_reg(REG_SPARE_LO, FREQ_MAX);
    write_reg(REG_SPARE_HI, FREQ_MAX);
    n_settings++;
    @(posedge clk);
    queue_meas(160000000, 50, 12, 1'b1);
    queue_meas(FREQ_MAX, 255, 13, 1'b1);
    queue_meas(500000000, 128, 200, 1'b0);
    queue_meas(500000000, 128, 201, 1'b1);
    settle();

    write_reg(REG_THRESHOLD, {19'd0, THR_MAX});
    n_settings++;
    @(posedge clk);
    queue_meas(500000000, 255, 14, 1'b1);   // 115 is not above 115: quiet
    settle();

    // Random phases, a new register set each time; the sender idles at each boundary.
    for (ph = 0; ph < 6; ph++) begin
      random_config(ph == 2 || ph == 4);
      @(posedge clk);
      queue_sweeps(80);
      settle();
    end

    // Back-pressure: every sweep end reports, receiver holds off while the
    // sender keeps offering, so the summary queue fills and in_ready drops.
    write_reg(REG_HOLD, 0);
    write_reg(REG_THRESHOLD, {19'd0, THR_MIN});
    n_settings++;
    @(posedge clk);
    stall_asks++;
    for (k = 0; k < 40; k++)
      queue_meas(pick_band_freq(), RAW_W'($urandom), CHAN_W'($urandom),
                 $urandom_range(0, 3) != 0);
    settle();

    $display("covered %0d measurement transactions over %0d register settings", n_accepted,
             n_settings);
    $display("reports checked: %0d detections, %0d cleared; %0d field errors", n_detect,
             n_cleared, n_errors);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/spt_pkg.sv
hw/rtl/spt_front.sv
hw/rtl/spt_queue.sv
hw/rtl/spt_back.sv
hw/rtl/sweep_peak_tracker.sv
hw/rtl/spt_checker.sv
tb/sv/tb_top.sv
